/* rtl/arpm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpm_pkg: shared types and constants of the AC RMS and peak meter
// Field widths, register indexes, reset values and state encodings that are
// shared by the lanes and the top level.
// ----------------------------------------------------------------------------
package arpm_pkg;

   localparam int GAIN_BITS      = 16;
   localparam int ZERO_BITS      = 12;
   localparam int WINDOW_BITS    = 16;
   localparam int VOLT_BITS      = 28;
   localparam int AMP_BITS       = 20;
   localparam int FRAC_BITS      = 8;
   localparam int MEAN_SHIFT     = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [VOLT_BITS-1:0] VOLT_MAX = {VOLT_BITS{1'b1}};
   localparam logic [AMP_BITS-1:0]  AMP_MAX  = {AMP_BITS{1'b1}};

   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_LEN   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ZERO_OFFSET  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VOLT_GAIN_Q8 = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_AMP_GAIN_Q8  = 2'd3;

   localparam logic [WINDOW_BITS-1:0] WINDOW_LEN_RESET   = 16'd40000;
   localparam logic [ZERO_BITS-1:0]   ZERO_OFFSET_RESET  = 12'd1977;
   localparam logic [GAIN_BITS-1:0]   VOLT_GAIN_RESET    = 16'd361;
   localparam logic [GAIN_BITS-1:0]   AMP_GAIN_RESET     = 16'd1459;

   typedef struct packed {
      logic frame;
      logic last;
   } frame_ctrl_type;

   typedef enum logic [2:0] {
      VS_IDLE,
      VS_DIV,
      VS_ROOT,
      VS_MUL,
      VS_SAT
   } volt_state_type;

   typedef enum logic {
      TS_RUN,
      TS_CALC
   } top_state_type;

endpackage

/* rtl/arpm_volt_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpm_volt_lane: one voltage channel
// Accumulates squared offset samples; at window end runs a bit-serial
// divide by the frame count, a two-bits-per-step square root and the
// Q8 gain scaling with saturation.
// ----------------------------------------------------------------------------
module arpm_volt_lane #(
   parameter int SAMPLE_BITS = 12,
   parameter int COUNT_BITS  = 16,
   parameter int ACC_BITS    = 40
) (
   input  logic                             clock,
   input  logic                             reset,
   input  arpm_pkg::frame_ctrl_type         frame_ctrl,
   input  logic [SAMPLE_BITS-1:0]           sample,
   input  logic [SAMPLE_BITS-1:0]           zero_code,
   input  logic [COUNT_BITS-1:0]            divisor,
   input  logic [arpm_pkg::GAIN_BITS-1:0]   gain,
   output logic                             done,
   output logic [arpm_pkg::VOLT_BITS-1:0]   volts
);
   import arpm_pkg::*;

   localparam int DIV_BITS  = ACC_BITS + MEAN_SHIFT;
   localparam int MEAN_BITS = (DIV_BITS > 64) ? 64 : DIV_BITS;
   localparam int ROOT_BITS = (MEAN_BITS + 1) / 2;
   localparam int STEP_BITS = $clog2(DIV_BITS + 1);
   localparam int PROD_BITS = ROOT_BITS + GAIN_BITS;
   localparam int WIDE_BITS = PROD_BITS + VOLT_BITS;

   volt_state_type state_ff, state_in;
   logic [ACC_BITS-1:0]      acc_ff, acc_in;
   logic [DIV_BITS-1:0]      dvd_ff, dvd_in;
   logic [COUNT_BITS-1:0]    rem_ff, rem_in;
   logic [COUNT_BITS-1:0]    dsr_ff, dsr_in;
   logic [STEP_BITS-1:0]     step_ff, step_in;
   logic [2*ROOT_BITS-1:0]   op_ff, op_in;
   logic [ROOT_BITS+1:0]     sqr_ff, sqr_in;
   logic [ROOT_BITS-1:0]     root_ff, root_in;
   logic [PROD_BITS-1:0]     prod_ff, prod_in;
   logic [VOLT_BITS-1:0]     volts_ff, volts_in;
   logic                     done_ff, done_in;

   logic [SAMPLE_BITS-1:0]   diff;
   logic [2*SAMPLE_BITS-1:0] square;
   logic [ACC_BITS-1:0]      acc_sum;
   logic [COUNT_BITS:0]      div_trial;
   logic                     quot_bit;
   logic [DIV_BITS-1:0]      quot_next;
   logic [ROOT_BITS+1:0]     root_cand;
   logic [ROOT_BITS+1:0]     root_trial;
   logic [WIDE_BITS-1:0]     scaled;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         VS_IDLE: begin
            if (frame_ctrl.frame && frame_ctrl.last) state_in = VS_DIV;
         end
         VS_DIV: begin
            if (step_ff == STEP_BITS'(DIV_BITS - 1)) state_in = VS_ROOT;
         end
         VS_ROOT: begin
            if (step_ff == STEP_BITS'(ROOT_BITS - 1)) state_in = VS_MUL;
         end
         VS_MUL: begin
            state_in = VS_SAT;
         end
         VS_SAT: begin
            state_in = VS_IDLE;
         end
         default: begin
            state_in = VS_IDLE;
         end
      endcase
   end

   // Outputs: done is registered at the same edge as the result register.
   always_comb begin
      done_in = (state_ff == VS_SAT);
   end

   always_comb begin
      diff    = (sample >= zero_code) ? (sample - zero_code) : (zero_code - sample);
      square  = (2*SAMPLE_BITS)'(diff) * (2*SAMPLE_BITS)'(diff);
      acc_sum = acc_ff + ACC_BITS'(square);

      div_trial = {rem_ff, dvd_ff[DIV_BITS-1]};
      quot_bit  = (div_trial >= {1'b0, dsr_ff});
      quot_next = {dvd_ff[DIV_BITS-2:0], quot_bit};

      root_cand  = {sqr_ff[ROOT_BITS-1:0], op_ff[2*ROOT_BITS-1 -: 2]};
      root_trial = {root_ff, 2'b01};

      scaled = WIDE_BITS'(prod_ff >> FRAC_BITS);

      acc_in   = acc_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      op_in    = op_ff;
      sqr_in   = sqr_ff;
      root_in  = root_ff;
      prod_in  = prod_ff;
      volts_in = volts_ff;
      step_in  = (state_in != state_ff) ? '0 : step_ff + 1'b1;

      if (frame_ctrl.frame) begin
         acc_in = frame_ctrl.last ? '0 : acc_sum;
      end

      case (state_ff)
         VS_IDLE: begin
            dvd_in = {acc_sum, {MEAN_SHIFT{1'b0}}};
            rem_in = '0;
            dsr_in = divisor;
         end
         VS_DIV: begin
            if (quot_bit) begin
               rem_in = COUNT_BITS'(div_trial - {1'b0, dsr_ff});
            end else begin
               rem_in = div_trial[COUNT_BITS-1:0];
            end
            dvd_in = quot_next;
            // The quotient is taken modulo 2 to the 64 when it is wider.
            op_in   = (2*ROOT_BITS)'(quot_next[MEAN_BITS-1:0]);
            sqr_in  = '0;
            root_in = '0;
         end
         VS_ROOT: begin
            op_in = op_ff << 2;
            if (root_cand >= root_trial) begin
               sqr_in  = root_cand - root_trial;
               root_in = {root_ff[ROOT_BITS-2:0], 1'b1};
            end else begin
               sqr_in  = root_cand;
               root_in = {root_ff[ROOT_BITS-2:0], 1'b0};
            end
         end
         VS_MUL: begin
            prod_in = PROD_BITS'(root_ff) * PROD_BITS'(gain);
         end
         VS_SAT: begin
            if (scaled > WIDE_BITS'(VOLT_MAX)) begin
               volts_in = VOLT_MAX;
            end else begin
               volts_in = scaled[VOLT_BITS-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= VS_IDLE;
         acc_ff   <= '0;
         done_ff  <= 1'b0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         acc_ff   <= acc_in;
         done_ff  <= done_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff   <= dvd_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
      op_ff    <= op_in;
      sqr_ff   <= sqr_in;
      root_ff  <= root_in;
      prod_ff  <= prod_in;
      volts_ff <= volts_in;
   end

   assign done  = done_ff;
   assign volts = volts_ff;

endmodule

/* rtl/arpm_amp_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpm_amp_lane: one current channel
// Tracks the running maximum and minimum with strict compares and turns
// the peak-to-peak span of a finished window into saturated milliamps.
// ----------------------------------------------------------------------------
module arpm_amp_lane #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   input  arpm_pkg::frame_ctrl_type        frame_ctrl,
   input  logic [SAMPLE_BITS-1:0]          sample,
   input  logic [arpm_pkg::GAIN_BITS-1:0]  gain,
   output logic [arpm_pkg::AMP_BITS-1:0]   amps
);
   import arpm_pkg::*;

   localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS;
   localparam int WIDE_BITS = PROD_BITS + AMP_BITS;

   logic [SAMPLE_BITS-1:0] hi_ff, hi_in;
   logic [SAMPLE_BITS-1:0] lo_ff, lo_in;
   logic [SAMPLE_BITS-1:0] span_ff, span_in;
   logic [AMP_BITS-1:0]    amps_ff, amps_in;

   logic [SAMPLE_BITS-1:0] new_hi;
   logic [SAMPLE_BITS-1:0] new_lo;
   logic [PROD_BITS-1:0]   prod;
   logic [WIDE_BITS-1:0]   scaled;

   always_comb begin
      new_hi = (sample > hi_ff) ? sample : hi_ff;
      new_lo = (sample < lo_ff) ? sample : lo_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      span_in = span_ff;
      if (frame_ctrl.frame) begin
         if (frame_ctrl.last) begin
            // An inverted pair of peaks counts as no span at all.
            span_in = (new_hi >= new_lo) ? (new_hi - new_lo) : '0;
            hi_in   = '0;
            lo_in   = '1;
         end else begin
            hi_in = new_hi;
            lo_in = new_lo;
         end
      end

      prod   = PROD_BITS'(span_ff) * PROD_BITS'(gain);
      scaled = WIDE_BITS'(prod >> FRAC_BITS);
      if (scaled > WIDE_BITS'(AMP_MAX)) begin
         amps_in = AMP_MAX;
      end else begin
         amps_in = scaled[AMP_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hi_ff <= '0;
         lo_ff <= '1;
      end else begin
         hi_ff <= hi_in;
         lo_ff <= lo_in;
      end
   end

   always_ff @(posedge clock) begin
      span_ff <= span_in;
      amps_ff <= amps_in;
   end

   assign amps = amps_ff;

endmodule

/* rtl/ac_rms_peak_meter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ac_rms_peak_meter: windowed RMS voltage and peak-to-peak current meter
// Two voltage lanes and two current lanes work on each frame side by side;
// the top level counts frames and merges the lane results into one record.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one converter frame per transfer (two voltage and two
//   current samples). rsp_* carries one result record per finished window.
//   csr_* writes window length, zero offset and the two Q8 gains; write
//   only while no window-end result is pending.
//   A frame that does not end the window is taken without a stall while no
//   window is being computed, so such frames can be transferred back to
//   back. The frame that ends the window starts the voltage lanes: a
//   one-bit-per-cycle divider, a two-bits-per-cycle square root, the gain
//   multiply and saturation steps, then the merge into the record.
//   req_stall stays high after that transfer until the record is valid.
//   While a record waits under rsp_stall, frames that do not end the window
//   are still taken; a window-ending frame is stalled until the record is
//   transferred.
//   Reset clears the sums, count and peaks and loads the default registers.
// ----------------------------------------------------------------------------
module ac_rms_peak_meter #(
   parameter int SAMPLE_BITS = 12,
   parameter int COUNT_BITS  = 16,
   parameter int ACC_BITS    = 40
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [SAMPLE_BITS-1:0]               req_volt_sample_a,
   input  logic [SAMPLE_BITS-1:0]               req_volt_sample_b,
   input  logic [SAMPLE_BITS-1:0]               req_amp_sample_a,
   input  logic [SAMPLE_BITS-1:0]               req_amp_sample_b,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [arpm_pkg::VOLT_BITS-1:0]       rsp_volts_a_q8,
   output logic [arpm_pkg::VOLT_BITS-1:0]       rsp_volts_b_q8,
   output logic [arpm_pkg::AMP_BITS-1:0]        rsp_amps_a_ma,
   output logic [arpm_pkg::AMP_BITS-1:0]        rsp_amps_b_ma,
   input  logic                                 csr_write,
   input  logic [arpm_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [arpm_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import arpm_pkg::*;

   localparam int CMP_BITS = (COUNT_BITS > WINDOW_BITS) ? COUNT_BITS : WINDOW_BITS;

   top_state_type state_ff, state_in;

   logic [WINDOW_BITS-1:0] window_len_ff;
   logic [ZERO_BITS-1:0]   zero_offset_ff;
   logic [GAIN_BITS-1:0]   volt_gain_ff;
   logic [GAIN_BITS-1:0]   amp_gain_ff;

   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   done_a_ff, done_a_in;
   logic                   done_b_ff, done_b_in;
   logic [VOLT_BITS-1:0]   volts_a_ff, volts_b_ff;
   logic [AMP_BITS-1:0]    amps_a_ff, amps_b_ff;

   logic [COUNT_BITS-1:0]             count_next;
   logic [COUNT_BITS-1:0]             divisor;
   logic                              end_now;
   logic                              capture;
   logic [SAMPLE_BITS+ZERO_BITS-1:0]  zero_wide;
   logic [SAMPLE_BITS-1:0]            zero_code;
   frame_ctrl_type                    frame_ctrl;
   logic                              volt_done_a, volt_done_b;
   logic [VOLT_BITS-1:0]              lane_volts_a, lane_volts_b;
   logic [AMP_BITS-1:0]               lane_amps_a, lane_amps_b;

   always_comb begin
      count_next = count_ff + 1'b1;
      end_now    = (CMP_BITS'(count_next) >= CMP_BITS'(window_len_ff));
      divisor    = (count_next == '0) ? COUNT_BITS'(1) : count_next;
      zero_wide  = {{SAMPLE_BITS{1'b0}}, zero_offset_ff};
      zero_code  = zero_wide[SAMPLE_BITS-1:0];
      capture    = (state_ff == TS_CALC) && (done_a_ff || volt_done_a)
                   && (done_b_ff || volt_done_b);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         TS_RUN: begin
            if (frame_ctrl.frame && end_now) state_in = TS_CALC;
         end
         TS_CALC: begin
            if (capture) state_in = TS_RUN;
         end
         default: begin
            state_in = TS_RUN;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      req_stall        = (state_ff == TS_CALC) || (rsp_valid_ff && end_now);
      frame_ctrl.frame = req_valid && !req_stall;
      frame_ctrl.last  = end_now;
   end

   always_comb begin
      count_in = count_ff;
      if (frame_ctrl.frame) begin
         count_in = end_now ? '0 : count_next;
      end
      done_a_in = capture ? 1'b0 : (done_a_ff || volt_done_a);
      done_b_in = capture ? 1'b0 : (done_b_ff || volt_done_b);
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (capture) rsp_valid_in = 1'b1;
   end

   arpm_volt_lane #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_BITS),
      .ACC_BITS    (ACC_BITS)
   ) u_volt_a (
      .clock      (clock),
      .reset      (reset),
      .frame_ctrl (frame_ctrl),
      .sample     (req_volt_sample_a),
      .zero_code  (zero_code),
      .divisor    (divisor),
      .gain       (volt_gain_ff),
      .done       (volt_done_a),
      .volts      (lane_volts_a)
   );

   arpm_volt_lane #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_BITS),
      .ACC_BITS    (ACC_BITS)
   ) u_volt_b (
      .clock      (clock),
      .reset      (reset),
      .frame_ctrl (frame_ctrl),
      .sample     (req_volt_sample_b),
      .zero_code  (zero_code),
      .divisor    (divisor),
      .gain       (volt_gain_ff),
      .done       (volt_done_b),
      .volts      (lane_volts_b)
   );

   arpm_amp_lane #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_amp_a (
      .clock      (clock),
      .reset      (reset),
      .frame_ctrl (frame_ctrl),
      .sample     (req_amp_sample_a),
      .gain       (amp_gain_ff),
      .amps       (lane_amps_a)
   );

   arpm_amp_lane #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_amp_b (
      .clock      (clock),
      .reset      (reset),
      .frame_ctrl (frame_ctrl),
      .sample     (req_amp_sample_b),
      .gain       (amp_gain_ff),
      .amps       (lane_amps_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff  <= WINDOW_LEN_RESET;
         zero_offset_ff <= ZERO_OFFSET_RESET;
         volt_gain_ff   <= VOLT_GAIN_RESET;
         amp_gain_ff    <= AMP_GAIN_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_WINDOW_LEN:   window_len_ff  <= csr_data[WINDOW_BITS-1:0];
            CSR_ZERO_OFFSET:  zero_offset_ff <= csr_data[ZERO_BITS-1:0];
            CSR_VOLT_GAIN_Q8: volt_gain_ff   <= csr_data[GAIN_BITS-1:0];
            CSR_AMP_GAIN_Q8:  amp_gain_ff    <= csr_data[GAIN_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TS_RUN;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         done_a_ff    <= 1'b0;
         done_b_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         done_a_ff    <= done_a_in;
         done_b_ff    <= done_b_in;
      end
   end

   // Merge the four lane results into the output record.
   always_ff @(posedge clock) begin
      if (capture) begin
         volts_a_ff <= lane_volts_a;
         volts_b_ff <= lane_volts_b;
         amps_a_ff  <= lane_amps_a;
         amps_b_ff  <= lane_amps_b;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_volts_a_q8 = volts_a_ff;
   assign rsp_volts_b_q8 = volts_b_ff;
   assign rsp_amps_a_ma  = amps_a_ff;
   assign rsp_amps_b_ma  = amps_b_ff;

   // A record can only be pending when no window result is being computed.
   a_no_pending_in_calc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == TS_CALC) |-> !rsp_valid_ff)
      else $error("result pending while a window is being computed");

   a_end_starts_calc: assert property (@(posedge clock) disable iff (reset)
      (frame_ctrl.frame && end_now) |=> (state_ff == TS_CALC))
      else $error("window-ending transfer did not start the calculation");

   a_lanes_lockstep: assert property (@(posedge clock) disable iff (reset)
      volt_done_a == volt_done_b)
      else $error("voltage lanes finished in different cycles");

   a_valid_from_calc: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == TS_CALC))
      else $error("result raised outside a calculation");

endmodule

/* verif/arpm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpm_checker: scoreboard for the AC RMS and peak meter
// Watches the register port and both channels, keeps its own copy of the
// window state, predicts one reading per finished window and compares every
// result transfer field by field with the oldest predicted reading.
// ----------------------------------------------------------------------------
module arpm_checker #(
   parameter int SAMPLE_BITS = 12,
   parameter int COUNT_BITS  = 16,
   parameter int ACC_BITS    = 40
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic [SAMPLE_BITS-1:0]               req_volt_sample_a,
   input  logic [SAMPLE_BITS-1:0]               req_volt_sample_b,
   input  logic [SAMPLE_BITS-1:0]               req_amp_sample_a,
   input  logic [SAMPLE_BITS-1:0]               req_amp_sample_b,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic [arpm_pkg::VOLT_BITS-1:0]       rsp_volts_a_q8,
   input  logic [arpm_pkg::VOLT_BITS-1:0]       rsp_volts_b_q8,
   input  logic [arpm_pkg::AMP_BITS-1:0]        rsp_amps_a_ma,
   input  logic [arpm_pkg::AMP_BITS-1:0]        rsp_amps_b_ma,
   input  logic                                 csr_write,
   input  logic [arpm_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [arpm_pkg::CSR_DATA_BITS-1:0]   csr_data,
   output int unsigned                          mismatch_count,
   output int unsigned                          pending_count,
   output int unsigned                          readings_checked
);
   import arpm_pkg::*;

   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [VOLT_BITS-1:0] volts_a;
      logic [VOLT_BITS-1:0] volts_b;
      logic [AMP_BITS-1:0]  amps_a;
      logic [AMP_BITS-1:0]  amps_b;
   } meter_reading_type;

   meter_reading_type expected_readings[$];

   logic [WINDOW_BITS-1:0] window_len;
   logic [ZERO_BITS-1:0]   zero_offset;
   logic [GAIN_BITS-1:0]   volt_gain;
   logic [GAIN_BITS-1:0]   amp_gain;

   logic [ACC_BITS-1:0]    sumsq_a;
   logic [ACC_BITS-1:0]    sumsq_b;
   logic [COUNT_BITS-1:0]  frames_in_window;
   logic [SAMPLE_BITS-1:0] hi_a;
   logic [SAMPLE_BITS-1:0] lo_a;
   logic [SAMPLE_BITS-1:0] hi_b;
   logic [SAMPLE_BITS-1:0] lo_b;

   function automatic logic [ACC_BITS-1:0] square_dev(input logic [SAMPLE_BITS-1:0] s);
      logic [SAMPLE_BITS-1:0] z;
      logic [SAMPLE_BITS-1:0] d;
      z = SAMPLE_BITS'(zero_offset);
      d = (s >= z) ? s - z : z - s;
      return ACC_BITS'(d) * ACC_BITS'(d);
   endfunction

   // Bit-by-bit search for the largest root whose square does not exceed v.
   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] root;
      logic [63:0] trial;
      root = 64'd0;
      for (int i = 31; i >= 0; i--) begin
         trial = root | (64'd1 << i);
         if (trial * trial <= v) begin
            root = trial;
         end
      end
      return root;
   endfunction

   function automatic logic [VOLT_BITS-1:0] rms_volts(input logic [ACC_BITS-1:0] sum,
                                                       input logic [COUNT_BITS-1:0] n);
      logic [63:0] mean_q16;
      logic [63:0] scaled;
      mean_q16 = (64'(sum) << MEAN_SHIFT) / 64'(n);
      scaled = (int_sqrt(mean_q16) * 64'(volt_gain)) >> FRAC_BITS;
      return (scaled > 64'(VOLT_MAX)) ? VOLT_MAX : scaled[VOLT_BITS-1:0];
   endfunction

   function automatic logic [AMP_BITS-1:0] span_amps(input logic [SAMPLE_BITS-1:0] hi,
                                                      input logic [SAMPLE_BITS-1:0] lo);
      logic [63:0] span;
      logic [63:0] scaled;
      span = (hi >= lo) ? 64'(hi - lo) : 64'd0;
      scaled = (span * 64'(amp_gain)) >> FRAC_BITS;
      return (scaled > 64'(AMP_MAX)) ? AMP_MAX : scaled[AMP_BITS-1:0];
   endfunction

   task automatic clear_window();
      sumsq_a          = '0;
      sumsq_b          = '0;
      frames_in_window = '0;
      hi_a             = '0;
      hi_b             = '0;
      lo_a             = '1;
      lo_b             = '1;
   endtask

   always @(posedge clock) begin : track
      meter_reading_type want;
      meter_reading_type got;
      logic [COUNT_BITS-1:0] divisor;
      if (reset) begin
         window_len  = WINDOW_LEN_RESET;
         zero_offset = ZERO_OFFSET_RESET;
         volt_gain   = VOLT_GAIN_RESET;
         amp_gain    = AMP_GAIN_RESET;
         clear_window();
         expected_readings.delete();
         mismatch_count   = 0;
         readings_checked = 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_WINDOW_LEN: begin
                  window_len = csr_data[WINDOW_BITS-1:0];
               end
               CSR_ZERO_OFFSET: begin
                  zero_offset = csr_data[ZERO_BITS-1:0];
               end
               CSR_VOLT_GAIN_Q8: begin
                  volt_gain = csr_data[GAIN_BITS-1:0];
               end
               CSR_AMP_GAIN_Q8: begin
                  amp_gain = csr_data[GAIN_BITS-1:0];
               end
               default: begin
               end
            endcase
         end

         if (req_valid && !req_stall) begin
            sumsq_a = sumsq_a + square_dev(req_volt_sample_a);
            sumsq_b = sumsq_b + square_dev(req_volt_sample_b);
            if (req_amp_sample_a > hi_a) hi_a = req_amp_sample_a;
            if (req_amp_sample_a < lo_a) lo_a = req_amp_sample_a;
            if (req_amp_sample_b > hi_b) hi_b = req_amp_sample_b;
            if (req_amp_sample_b < lo_b) lo_b = req_amp_sample_b;
            frames_in_window = frames_in_window + 1'b1;
            // A window length of zero makes every frame close the window.
            if (frames_in_window >= window_len) begin
               divisor = (frames_in_window == '0) ? COUNT_BITS'(1) : frames_in_window;
               want.volts_a = rms_volts(sumsq_a, divisor);
               want.volts_b = rms_volts(sumsq_b, divisor);
               want.amps_a  = span_amps(hi_a, lo_a);
               want.amps_b  = span_amps(hi_b, lo_b);
               expected_readings.push_back(want);
               clear_window();
            end
         end

         if (rsp_valid && !rsp_stall) begin
            got.volts_a = rsp_volts_a_q8;
            got.volts_b = rsp_volts_b_q8;
            got.amps_a  = rsp_amps_a_ma;
            got.amps_b  = rsp_amps_b_ma;
            if (expected_readings.size() == 0) begin
               if (mismatch_count < MAX_REPORTS) begin
                  $display("%0t: unexpected reading volts %0d/%0d amps %0d/%0d", $realtime,
                           got.volts_a, got.volts_b, got.amps_a, got.amps_b);
               end
               mismatch_count++;
            end else begin
               want = expected_readings.pop_front();
               readings_checked++;
               if (got !== want) begin
                  if (mismatch_count < MAX_REPORTS) begin
                     $display("%0t: reading %0d differs", $realtime, readings_checked);
                     $display("   volts_a expected %0d got %0d", want.volts_a, got.volts_a);
                     $display("   volts_b expected %0d got %0d", want.volts_b, got.volts_b);
                     $display("   amps_a  expected %0d got %0d", want.amps_a, got.amps_a);
                     $display("   amps_b  expected %0d got %0d", want.amps_b, got.amps_b);
                  end
                  mismatch_count++;
               end
            end
         end
      end
      pending_count = expected_readings.size();
   end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the AC RMS and peak meter
// Drives converter frames under a series of register settings, first a short
// directed set of extreme samples and window lengths, then random windows.
// Both sides idle and stall at random; the checker beside the block predicts
// and compares every reading.
// ----------------------------------------------------------------------------
module tb_top;
   import arpm_pkg::*;

   localparam int SAMPLE_BITS   = 12;
   localparam int COUNT_BITS    = 16;
   localparam int ACC_BITS      = 40;
   localparam int CLOCK_PERIOD  = 20;
   localparam int RESET_CYCLES  = 7;
   localparam int DRAIN_CYCLES  = 100;
   localparam int LONG_HOLD     = 400;
   localparam int TARGET_FRAMES = 1500;
   localparam int FULL_SCALE    = (1 << SAMPLE_BITS) - 1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [SAMPLE_BITS-1:0]        req_volt_sample_a = '0;
   logic [SAMPLE_BITS-1:0]        req_volt_sample_b = '0;
   logic [SAMPLE_BITS-1:0]        req_amp_sample_a = '0;
   logic [SAMPLE_BITS-1:0]        req_amp_sample_b = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [VOLT_BITS-1:0]          rsp_volts_a_q8;
   logic [VOLT_BITS-1:0]          rsp_volts_b_q8;
   logic [AMP_BITS-1:0]           rsp_amps_a_ma;
   logic [AMP_BITS-1:0]           rsp_amps_b_ma;
   logic                          csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0]     csr_index = CSR_WINDOW_LEN;
   logic [CSR_DATA_BITS-1:0]      csr_data = '0;

   int unsigned mismatch_count;
   int unsigned pending_count;
   int unsigned readings_checked;

   int unsigned frames_sent = 0;
   int unsigned settings_used = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   bit          hold_request = 1'b0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   ac_rms_peak_meter #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .COUNT_BITS (COUNT_BITS),
      .ACC_BITS   (ACC_BITS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_volt_sample_a(req_volt_sample_a),
      .req_volt_sample_b(req_volt_sample_b),
      .req_amp_sample_a (req_amp_sample_a),
      .req_amp_sample_b (req_amp_sample_b),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_volts_a_q8   (rsp_volts_a_q8),
      .rsp_volts_b_q8   (rsp_volts_b_q8),
      .rsp_amps_a_ma    (rsp_amps_a_ma),
      .rsp_amps_b_ma    (rsp_amps_b_ma),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   arpm_checker #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .COUNT_BITS (COUNT_BITS),
      .ACC_BITS   (ACC_BITS)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_volt_sample_a(req_volt_sample_a),
      .req_volt_sample_b(req_volt_sample_b),
      .req_amp_sample_a (req_amp_sample_a),
      .req_amp_sample_b (req_amp_sample_b),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_volts_a_q8   (rsp_volts_a_q8),
      .rsp_volts_b_q8   (rsp_volts_b_q8),
      .rsp_amps_a_ma    (rsp_amps_a_ma),
      .rsp_amps_b_ma    (rsp_amps_b_ma),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count),
      .readings_checked (readings_checked)
   );

   // Result side: random stall, or one long hold-off when asked for.
   initial begin : result_side
      int unsigned held;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            held = 1;
            while (held < LONG_HOLD) begin
               @(posedge clock);
               held++;
            end
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   task automatic send_frame(input logic [SAMPLE_BITS-1:0] volt_a, input logic [SAMPLE_BITS-1:0] volt_b,
                             input logic [SAMPLE_BITS-1:0] amp_a, input logic [SAMPLE_BITS-1:0] amp_b);
      if (frames_sent < TARGET_FRAMES / 3) begin
         send_idle_pct = 25;
         recv_idle_pct = 67;
      end else if (frames_sent < 2 * TARGET_FRAMES / 3) begin
         send_idle_pct = 67;
         recv_idle_pct = 25;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_volt_sample_a <= volt_a;
      req_volt_sample_b <= volt_b;
      req_amp_sample_a  <= amp_a;
      req_amp_sample_b  <= amp_b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      frames_sent++;
   endtask

   // Stop offering frames until every reading is out and the block is quiet.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_count == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
   endtask

   task automatic configure(input logic [15:0] wlen, input logic [15:0] zoff,
                            input logic [15:0] vgain, input logic [15:0] again);
      settle();
      write_reg(CSR_WINDOW_LEN, wlen);
      write_reg(CSR_ZERO_OFFSET, zoff);
      write_reg(CSR_VOLT_GAIN_Q8, vgain);
      write_reg(CSR_AMP_GAIN_Q8, again);
      csr_write <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [SAMPLE_BITS-1:0] volt_sample(input int center, input int swing);
      int unsigned mode;
      mode = $urandom_range(9);
      if (mode == 0) begin
         return ($urandom_range(1) == 1) ? SAMPLE_BITS'(FULL_SCALE) : '0;
      end else if (mode < 7) begin
         return SAMPLE_BITS'(center + int'($urandom_range(2 * swing)) - swing);
      end
      return SAMPLE_BITS'($urandom);
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] amp_sample(input int band_lo, input int band_width);
      if ($urandom_range(9) == 0) begin
         return SAMPLE_BITS'($urandom);
      end
      return SAMPLE_BITS'(band_lo + int'($urandom_range(band_width)));
   endfunction

   function automatic logic [15:0] pick_gain();
      int unsigned r;
      r = $urandom_range(9);
      if (r == 0) return 16'd0;
      if (r == 1) return 16'hFFFF;
      return 16'($urandom);
   endfunction

   initial begin : stimulus
      int unsigned r;
      int unsigned wlen;
      int unsigned nframes;
      int          zoff;
      int          swing;
      int          band_lo;
      int          band_width;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset register values: two frames under the default length, then a
      // shorter length closes the window with the default offset and gains.
      send_frame('0, SAMPLE_BITS'(FULL_SCALE), SAMPLE_BITS'(FULL_SCALE), '0);
      send_frame(SAMPLE_BITS'(FULL_SCALE), '0, '0, SAMPLE_BITS'(FULL_SCALE));
      settle();
      write_reg(CSR_WINDOW_LEN, 16'd3);
      csr_write <= 1'b0;
      send_frame(12'd2048, 12'd1977, 12'd2000, 12'd2000);

      // Single-frame windows with the largest gains and a zero offset.
      configure(16'd1, 16'd0, 16'hFFFF, 16'hFFFF);
      send_frame('0, SAMPLE_BITS'(FULL_SCALE), '0, SAMPLE_BITS'(FULL_SCALE));
      send_frame(SAMPLE_BITS'(FULL_SCALE), '0, SAMPLE_BITS'(FULL_SCALE), SAMPLE_BITS'(FULL_SCALE));

      // Full-scale offset and full-scale current spans.
      configure(16'd2, 16'(FULL_SCALE), 16'hFFFF, 16'hFFFF);
      send_frame('0, '0, '0, SAMPLE_BITS'(FULL_SCALE));
      send_frame(SAMPLE_BITS'(FULL_SCALE), SAMPLE_BITS'(FULL_SCALE), SAMPLE_BITS'(FULL_SCALE), '0);

      // Zero window length and zero gains.
      configure(16'd0, 16'd2048, 16'd0, 16'd0);
      send_frame(12'd100, 12'd4000, 12'd7, 12'd4088);
      send_frame(12'd3000, 12'd5, 12'd4088, 12'd7);

      // Longest window, then the length is lowered in the middle of it.
      configure(16'hFFFF, 16'd1024, 16'd256, 16'd256);
      repeat (5) begin
         send_frame(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom),
                    SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom));
      end
      settle();
      write_reg(CSR_WINDOW_LEN, 16'd2);
      csr_write <= 1'b0;
      send_frame(12'd0, 12'd4095, 12'd1500, 12'd2500);

      // Alternating bit patterns on every sample field and the offset, then all-ones and all-zeros samples.
      configure(16'd4, 16'hAAA, 16'd12345, 16'd54321);
      send_frame(12'hAAA, 12'h555, 12'hAAA, 12'h555);
      send_frame(12'h555, 12'hAAA, 12'h555, 12'hAAA);
      send_frame(12'hFFF, 12'h000, 12'h000, 12'hFFF);
      send_frame(12'h000, 12'hFFF, 12'hFFF, 12'h000);

      // Long hold-off on the result side while frames keep coming, so that a
      // window-ending frame backs up behind the waiting reading.
      configure(16'd3, 16'd2048, 16'd361, 16'd1459);
      hold_request = 1'b1;
      repeat (30) begin
         send_frame(volt_sample(2048, 1500), volt_sample(2048, 1500),
                    SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom));
      end

      while (frames_sent < TARGET_FRAMES) begin
         r = $urandom_range(99);
         if (r < 10) wlen = $urandom_range(1);
         else if (r < 65) wlen = $urandom_range(8, 2);
         else if (r < 92) wlen = $urandom_range(64, 9);
         else wlen = $urandom_range(300, 65);

         if (wlen <= 1) nframes = $urandom_range(12, 2);
         else nframes = wlen * $urandom_range(3, 1) + $urandom_range(wlen - 1);
         if (nframes > 400) nframes = 400;

         r = $urandom_range(99);
         if (r < 10) zoff = 0;
         else if (r < 20) zoff = FULL_SCALE;
         else if (r < 80) zoff = $urandom_range(2300, 1700);
         else zoff = $urandom_range(FULL_SCALE);

         swing = $urandom_range(2047, 1);
         band_lo = $urandom_range(FULL_SCALE);
         band_width = $urandom_range(FULL_SCALE - band_lo);

         configure(16'(wlen), 16'(zoff), pick_gain(), pick_gain());
         repeat (nframes) begin
            send_frame(volt_sample(zoff, swing), volt_sample(zoff, swing),
                       amp_sample(band_lo, band_width), amp_sample(band_lo, band_width));
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_count == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d frames under %0d register settings, with idle and stall mixes.",
               frames_sent, settings_used);
      $display("%0d window readings were compared with predicted values.", readings_checked);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin : watchdog
      #(20_000_000);
      $display("Mismatches found");
      $finish;
   end

endmodule
